>>> hw/rtl/serial_led_command_decoder_defines.svh
// ----------------------------------------------------------------------------
// serial led command decoder assertion macros
// shared assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef SERIAL_LED_COMMAND_DECODER_DEFINES_SVH
`define SERIAL_LED_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SLD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// types, command table and helpers for the serial led command decoder
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int LEN_W    = $clog2(MAX_TEXT);
  localparam int NUM_CMDS = 12;
  localparam int CMD_W    = 4;
  localparam int NUM_LEDS = 4;
  localparam int LED_IW   = $clog2(NUM_LEDS);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [7:0] BYTE_NUL = 8'd0;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;

  localparam logic [CMD_W-1:0] CMD_NONE = '0;

  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_TGL
  } led_op_t;

  // three-byte command windows, in command order 1..12
  localparam logic [23:0] CMD_CODES [NUM_CMDS] = '{
    24'h4C5231, 24'h4C5230, 24'h4C5254,
    24'h4C4731, 24'h4C4730, 24'h4C4754,
    24'h4C4231, 24'h4C4230, 24'h4C4254,
    24'h4C6731, 24'h4C6730, 24'h4C6754
  };

  localparam logic [LED_IW-1:0] CMD_LED [NUM_CMDS] = '{
    2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
  };

  localparam led_op_t CMD_OP [NUM_CMDS] = '{
    OP_ON, OP_OFF, OP_TGL, OP_ON, OP_OFF, OP_TGL,
    OP_ON, OP_OFF, OP_TGL, OP_ON, OP_OFF, OP_TGL
  };

  // one classified byte handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ovf;
  } sld_entry_t;

  function automatic logic [NUM_LEDS-1:0] apply_cmd(input logic [NUM_LEDS-1:0] leds,
                                                    input logic [CMD_W-1:0]    cmd);
    logic [NUM_LEDS-1:0] res;
    logic [NUM_LEDS-1:0] m;
    logic [CMD_W-1:0]    k;
    res = leds;
    m   = '0;
    k   = '0;
    if (cmd != CMD_NONE && cmd <= CMD_W'(NUM_CMDS)) begin
      k = cmd - CMD_W'(1);
      m = NUM_LEDS'(1) << CMD_LED[k];
      case (CMD_OP[k])
        OP_ON:   res = leds | m;
        OP_OFF:  res = leds & ~m;
        OP_TGL:  res = leds ^ m;
        default: res = leds;
      endcase
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/serial_led_command_decoder.sv
// ----------------------------------------------------------------------------
// serial_led_command_decoder
// decodes three-byte led commands from a stream of received serial bytes
// ----------------------------------------------------------------------------
// One byte is taken per cycle and each byte yields exactly one result. The
// front end classifies a byte and matches its three-byte window
// combinationally; the back end applies the chosen command to the led states
// as it loads the result register. A two-entry queue between them lets the
// input keep flowing while the result register is held by a stall; the
// input stalls only once that queue is full. Text longer than MAX_TEXT-1
// bytes is cleared and flagged on the byte that hits the limit.
module serial_led_command_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_red_on,
  output logic       out_green_on,
  output logic       out_blue_on,
  output logic       out_second_green_on,
  output logic [3:0] out_applied_command,
  output logic       out_overflow_cleared
);
  import sld_pkg::*;

  logic       q_push, q_full, q_valid, q_pop;
  sld_entry_t q_wdata, q_rdata;

  sld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  sld_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .rvalid (q_valid),
    .pop    (q_pop),
    .rdata  (q_rdata)
  );

  sld_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_rdata              (q_rdata),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_red_on           (out_red_on),
    .out_green_on         (out_green_on),
    .out_blue_on          (out_blue_on),
    .out_second_green_on  (out_second_green_on),
    .out_applied_command  (out_applied_command),
    .out_overflow_cleared (out_overflow_cleared)
  );

endmodule

>>> hw/rtl/sld_front.sv
// ----------------------------------------------------------------------------
// sld_front
// accepts bytes, tracks line text and matches command windows
// ----------------------------------------------------------------------------
module sld_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output sld_pkg::sld_entry_t q_wdata
);
  import sld_pkg::*;

  logic [15:0]         recent_r, recent_nxt;
  logic [1:0]          count_r, count_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [NUM_CMDS-1:0] seen_r, seen_nxt;

  logic                is_term;
  logic [23:0]         win;
  logic [NUM_CMDS-1:0] hit;
  logic [CMD_W-1:0]    lowest;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_term  = (in_rx_byte == BYTE_NUL) || (in_rx_byte == BYTE_LF) ||
                    (in_rx_byte == BYTE_CR);
  assign win      = {recent_r, in_rx_byte};

  always_comb begin
    for (int k = 0; k < NUM_CMDS; k++) begin
      hit[k] = (win == CMD_CODES[k]);
    end
  end

  // lowest-numbered seen command wins
  always_comb begin
    lowest = CMD_NONE;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      if (seen_r[k]) begin
        lowest = CMD_W'(k + 1);
      end
    end
  end

  always_comb begin
    recent_nxt  = recent_r;
    count_nxt   = count_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    q_wdata.cmd = CMD_NONE;
    q_wdata.ovf = 1'b0;
    if (is_term) begin
      if (lowest != CMD_NONE) begin
        q_wdata.cmd = lowest;
        recent_nxt  = '0;
        count_nxt   = '0;
        len_nxt     = '0;
        seen_nxt    = '0;
      end
    end else if (len_r < LEN_W'(MAX_TEXT - 1)) begin
      if (count_r == 2'd2) begin
        seen_nxt = seen_r | hit;
      end
      recent_nxt = {recent_r[7:0], in_rx_byte};
      if (count_r != 2'd2) begin
        count_nxt = count_r + 2'd1;
      end
      len_nxt = len_r + LEN_W'(1);
    end else begin
      // length limit: drop the byte and clear the text
      q_wdata.ovf = 1'b1;
      recent_nxt  = '0;
      count_nxt   = '0;
      len_nxt     = '0;
      seen_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      count_r  <= '0;
      len_r    <= '0;
      seen_r   <= '0;
    end else if (q_push) begin
      recent_r <= recent_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

>>> hw/rtl/sld_queue.sv
// ----------------------------------------------------------------------------
// sld_queue
// short fifo between the classifying front and the led back end
// ----------------------------------------------------------------------------
module sld_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sld_pkg::sld_entry_t wdata,
  output logic                full,
  output logic                rvalid,
  input  logic                pop,
  output sld_pkg::sld_entry_t rdata
);
  import sld_pkg::*;

  sld_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/sld_back.sv
// ----------------------------------------------------------------------------
// sld_back
// applies commands to the led states and holds the result register
// ----------------------------------------------------------------------------
module sld_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sld_pkg::sld_entry_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_red_on,
  output logic                out_green_on,
  output logic                out_blue_on,
  output logic                out_second_green_on,
  output logic [3:0]          out_applied_command,
  output logic                out_overflow_cleared
);
  import sld_pkg::*;

  logic [NUM_LEDS-1:0] leds_r, leds_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic                ovf_r;
  logic                valid_r, valid_nxt;

  // take a new entry when the result register is empty or being drained
  assign q_pop    = q_valid && (!valid_r || !out_stall);
  assign leds_nxt = apply_cmd(leds_r, q_rdata.cmd);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (q_pop) begin
        leds_r <= leds_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_rdata.cmd;
      ovf_r <= q_rdata.ovf;
    end
  end

  assign out_valid            = valid_r;
  assign out_red_on           = leds_r[0];
  assign out_green_on         = leds_r[1];
  assign out_blue_on          = leds_r[2];
  assign out_second_green_on  = leds_r[3];
  assign out_applied_command  = cmd_r;
  assign out_overflow_cleared = ovf_r;

endmodule

>>> hw/rtl/sld_checker.sv
// ----------------------------------------------------------------------------
// sld_checker
// port-level checks on the serial led command decoder
// ----------------------------------------------------------------------------
`include "serial_led_command_decoder_defines.svh"

module sld_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_red_on,
  input logic       out_green_on,
  input logic       out_blue_on,
  input logic       out_second_green_on,
  input logic [3:0] out_applied_command,
  input logic       out_overflow_cleared
);
  import sld_pkg::*;

  logic [NUM_LEDS-1:0] leds;
  logic [NUM_LEDS-1:0] last_leds_r;
  logic                out_xfer;
  logic                in_xfer;

  assign leds     = {out_second_green_on, out_blue_on, out_green_on, out_red_on};
  assign out_xfer = out_valid && !out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // led states as of the last result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_leds_r <= '0;
    end else if (out_xfer) begin
      last_leds_r <= leds;
    end
  end

  `SLD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `SLD_ASSERT_IMP(a_cmd_range, out_valid, out_applied_command <= CMD_W'(NUM_CMDS),
                  "applied command out of range")
  `SLD_ASSERT_IMP(a_ovf_no_cmd, out_valid && out_overflow_cleared,
                  out_applied_command == CMD_NONE, "command applied on overflow")
  `SLD_ASSERT_IMP(a_leds_only_on_cmd, out_xfer && out_applied_command == CMD_NONE,
                  leds == last_leds_r, "leds changed without a command")
  `SLD_ASSERT_NXT(a_first_result, in_xfer && !out_valid, !in_stall,
                  "input stalled while back end empty")

endmodule

bind serial_led_command_decoder sld_checker u_sld_checker (.*);
